[rtl/core/swps_pkg.sv]
// Shared types, constants and codes for the strike window peak statistics core.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package swps_pkg;

    localparam int BINS_DEF   = 60;   // one-minute window of one-second bins
    localparam int SAMPLE_W   = 10;   // converter reading, peaks, margin, mean
    localparam int CNT_W      = 8;    // finished-bin count and strike count
    localparam int PCT_W      = 7;    // percentage field
    localparam int SUM_W      = 18;   // sum of up to 255 ten-bit peaks
    localparam int PCT_SCALE  = 100;

    localparam logic [SAMPLE_W-1:0] ADC_MAX    = 10'd1023;
    localparam logic [SAMPLE_W-1:0] BASE_RST   = 10'd512;
    localparam logic [SAMPLE_W-1:0] MARGIN_RST = 10'd10;
    localparam logic [PCT_W-1:0]    PCT_MAX    = 7'd100;

    // mode field codes; code 3 is unused and leaves the state alone
    localparam logic [1:0] MODE_CAL  = 2'd0;
    localparam logic [1:0] MODE_MEAS = 2'd1;
    localparam logic [1:0] MODE_TICK = 2'd2;

    typedef struct packed {
        logic [1:0]          mode;
        logic [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CNT_W-1:0]    strike_count;
        logic [SAMPLE_W-1:0] mean_intensity;
        logic [PCT_W-1:0]    intensity_percent;
        logic                ready_res;
    } out_item_t;

    // what every bin cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT,
        CELL_RAISE
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [CNT_W-1:0]    sel;
        logic [SAMPLE_W-1:0] dev;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MSTART,
        ST_MWAIT,
        ST_PSTART,
        ST_PWAIT,
        ST_EMIT
    } swps_state_t;

endpackage

[rtl/core/swps_cell.sv]
// One bin cell of the peak window chain: holds one bin peak.
// Depends on swps_pkg for widths and the cell control struct.
`timescale 1ns / 1ps

module swps_cell #(
    parameter int IDX = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  swps_pkg::cell_ctrl_t          ctrl,
    input  logic [swps_pkg::SAMPLE_W-1:0] nbr_in,
    output logic [swps_pkg::SAMPLE_W-1:0] peak_out
);
    import swps_pkg::*;

    logic [SAMPLE_W-1:0] peak_reg;
    logic [SAMPLE_W-1:0] peak_next;

    always_comb begin
        unique case (ctrl.op)
            CELL_HOLD:  peak_next = peak_reg;
            CELL_SHIFT: peak_next = nbr_in;
            CELL_RAISE: begin
                if (ctrl.sel == CNT_W'(IDX) && ctrl.dev > peak_reg) begin
                    peak_next = ctrl.dev;
                end else begin
                    peak_next = peak_reg;
                end
            end
            default:    peak_next = peak_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peak_reg <= '0;
        end else begin
            peak_reg <= peak_next;
        end
    end

    assign peak_out = peak_reg;

endmodule

[rtl/core/swps_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on swps_pkg for default widths.
`timescale 1ns / 1ps

module swps_div #(
    parameter int NW = swps_pkg::SUM_W,
    parameter int DW = swps_pkg::SAMPLE_W
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    import swps_pkg::*;

    localparam int CW = (NW > 1) ? $clog2(NW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_next;
    logic [DW-1:0] den_reg;
    logic [DW:0]   trial;
    logic          fits;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        trial    = {rem_reg, quo_reg[NW-1]};
        fits     = trial >= {1'b0, den_reg};
        rem_next = fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
        quo_next = {quo_reg[NW-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CW'(NW - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= '0;
            rem_reg <= '0;
            quo_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 1'b1;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[rtl/core/strike_window_peak_stats.sv]
// Top level of the strike window peak statistics core.
// Depends on swps_pkg, swps_cell (bin chain) and swps_div (shared divider).
`timescale 1ns / 1ps

// Lightning detector core. Calibration requests (mode 0) build the baseline
// until calibration ends, the first measurement request (mode 1) ends
// calibration and fixes full scale, every measurement request raises the peak
// deviation of the current one-second bin, and calibrated tick requests
// (mode 2) close the bin and recompute the strike statistics over the finished
// bins. Every request returns exactly one result. A calibrated tick rotates
// the bin chain once, one bin a cycle past the accumulator, and when at least
// one bin counts as a strike the shared bit-serial divider then works out
// first the mean and then the percentage, 18 quotient bits each; when none
// does, the statistics are cleared to zero. A result still waiting on m_ready
// when the next one is due holds the block in its emit state until it is taken.
// One request is in work at a time; s_ready is high in idle even while the
// last result waits on m_ready. strike_margin is written through
// cfg_we/cfg_data; the user must write it only while the block is idle, as
// the block itself does not enforce it.
module strike_window_peak_stats #(
    parameter int BINS = swps_pkg::BINS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  swps_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output swps_pkg::out_item_t           m_data,
    input  logic                          cfg_we,
    input  logic [swps_pkg::SAMPLE_W-1:0] cfg_data
);
    import swps_pkg::*;

    localparam int KW = (BINS > 1) ? $clog2(BINS) : 1;

    // control and calibration state
    swps_state_t         state_reg, state_next;
    logic                cal_reg;
    logic                started_reg;
    logic [SAMPLE_W-1:0] base_reg;
    logic [SAMPLE_W-1:0] fs_reg;
    logic [CNT_W-1:0]    bins_done_reg;
    logic [SAMPLE_W-1:0] margin_reg;

    // held statistics
    logic [CNT_W-1:0]    strikes_reg;
    logic [SAMPLE_W-1:0] mean_reg;
    logic [PCT_W-1:0]    pct_reg;

    // scan accumulator
    logic [KW-1:0]       k_reg;
    logic [CNT_W-1:0]    acc_cnt_reg;
    logic [SUM_W-1:0]    acc_sum_reg;

    // result register
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic                accept;
    logic                full;
    logic                scan_last;
    logic [SAMPLE_W-1:0] dev;
    logic [SAMPLE_W-1:0] fs_cand;
    logic [SAMPLE_W:0]   base_sum;
    cell_ctrl_t          cell_ctrl;
    logic [SAMPLE_W-1:0] peak_w [BINS];
    logic [SAMPLE_W-1:0] last_feed;
    logic                out_free;

    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_num;
    logic [SAMPLE_W-1:0] div_den;
    logic [SUM_W-1:0]    div_quo;
    logic [SUM_W-1:0]    mean_x100;

    assign accept    = s_valid && s_ready;
    assign full      = ({1'b0, bins_done_reg} + 9'd1) >= 9'(BINS);
    assign scan_last = k_reg == KW'(BINS - 1);
    assign out_free  = !m_valid_reg || m_ready;
    assign dev       = (s_data.sample >= base_reg) ? (s_data.sample - base_reg)
                                                   : (base_reg - s_data.sample);
    assign fs_cand   = (base_reg > (ADC_MAX - base_reg)) ? base_reg
                                                         : (ADC_MAX - base_reg);
    assign base_sum  = {1'b0, base_reg} + {1'b0, s_data.sample};
    assign mean_x100 = SUM_W'(mean_reg) * SUM_W'(PCT_SCALE);

    // rotate the chain during a scan, feed an empty bin when shifting the window
    assign last_feed = (state_reg == ST_SCAN) ? peak_w[0] : '0;

    // ---------------------------------------------------------------
    // bin chain: cell i takes its upper neighbor on a shift
    // ---------------------------------------------------------------
    for (genvar i = 0; i < BINS; i++) begin : g_cell
        if (i < BINS - 1) begin : g_mid
            swps_cell #(.IDX(i)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .nbr_in   (peak_w[i+1]),
                .peak_out (peak_w[i])
            );
        end else begin : g_end
            swps_cell #(.IDX(i)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctrl     (cell_ctrl),
                .nbr_in   (last_feed),
                .peak_out (peak_w[i])
            );
        end
    end

    // ---------------------------------------------------------------
    // shared divider: mean first, then percentage
    // ---------------------------------------------------------------
    assign div_num = (state_reg == ST_MSTART) ? acc_sum_reg : mean_x100;
    assign div_den = (state_reg == ST_MSTART) ? SAMPLE_W'(acc_cnt_reg) : fs_reg;

    swps_div #(.NW(SUM_W), .DW(SAMPLE_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ---------------------------------------------------------------
    // next state
    // ---------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.mode == MODE_TICK && cal_reg) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_MSTART;
                end
            end
            ST_MSTART: begin
                state_next = (acc_cnt_reg == '0) ? ST_EMIT : ST_MWAIT;
            end
            ST_MWAIT: begin
                if (div_done) begin
                    state_next = ST_PSTART;
                end
            end
            ST_PSTART: state_next = ST_PWAIT;
            ST_PWAIT: begin
                if (div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // state outputs
    // ---------------------------------------------------------------
    always_comb begin
        s_ready       = 1'b0;
        div_start     = 1'b0;
        cell_ctrl.op  = CELL_HOLD;
        cell_ctrl.sel = bins_done_reg;
        cell_ctrl.dev = dev;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    if (s_data.mode == MODE_MEAS) begin
                        cell_ctrl.op = CELL_RAISE;
                    end else if (s_data.mode == MODE_TICK && cal_reg && full) begin
                        cell_ctrl.op = CELL_SHIFT;
                    end
                end
            end
            ST_SCAN:   cell_ctrl.op = CELL_SHIFT;
            ST_MSTART: div_start = acc_cnt_reg != '0;
            ST_PSTART: div_start = 1'b1;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // control registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cal_reg       <= 1'b0;
            started_reg   <= 1'b0;
            base_reg      <= BASE_RST;
            fs_reg        <= BASE_RST;
            bins_done_reg <= '0;
            margin_reg    <= MARGIN_RST;
            strikes_reg   <= '0;
            mean_reg      <= '0;
            pct_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                margin_reg <= cfg_data;
            end

            if (accept) begin
                // hold the baseline once calibration has ended
                if (s_data.mode == MODE_CAL && !cal_reg) begin
                    started_reg <= 1'b1;
                    base_reg    <= started_reg ? base_sum[SAMPLE_W:1] : s_data.sample;
                end
                // first measurement ends calibration
                if (s_data.mode == MODE_MEAS && !cal_reg) begin
                    cal_reg <= 1'b1;
                    fs_reg  <= fs_cand;
                end
                // advance the window; once full it shifts and the count stays
                if (s_data.mode == MODE_TICK && cal_reg && !full) begin
                    bins_done_reg <= bins_done_reg + 1'b1;
                end
            end

            if (state_reg == ST_MSTART && acc_cnt_reg == '0) begin
                strikes_reg <= '0;
                mean_reg    <= '0;
                pct_reg     <= '0;
            end
            if (state_reg == ST_MWAIT && div_done) begin
                strikes_reg <= acc_cnt_reg;
                mean_reg    <= div_quo[SAMPLE_W-1:0];
            end
            if (state_reg == ST_PWAIT && div_done) begin
                if (fs_reg == '0) begin
                    pct_reg <= '0;
                end else if (div_quo > SUM_W'(PCT_MAX)) begin
                    pct_reg <= PCT_MAX;
                end else begin
                    pct_reg <= div_quo[PCT_W-1:0];
                end
            end

            if (state_reg == ST_EMIT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // scan accumulator and result payload
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            k_reg       <= '0;
            acc_cnt_reg <= '0;
            acc_sum_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            // cell 0 holds bin k after k rotations
            k_reg <= k_reg + 1'b1;
            if (CNT_W'(k_reg) < bins_done_reg && peak_w[0] > margin_reg) begin
                acc_cnt_reg <= acc_cnt_reg + 1'b1;
                acc_sum_reg <= acc_sum_reg + SUM_W'(peak_w[0]);
            end
        end

        if (state_reg == ST_EMIT && out_free) begin
            m_data_reg.strike_count      <= cal_reg ? strikes_reg : '0;
            m_data_reg.mean_intensity    <= cal_reg ? mean_reg : '0;
            m_data_reg.intensity_percent <= cal_reg ? pct_reg : '0;
            m_data_reg.ready_res         <= cal_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_one_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("request accepted while another is in work");

    a_bins_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        bins_done_reg <= CNT_W'(BINS - 1))
        else $error("finished-bin count past window size");

    a_cal_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        cal_reg |=> cal_reg)
        else $error("calibration flag dropped");

    a_uncal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.ready_res) |->
            (m_data.strike_count == '0 && m_data.mean_intensity == '0
             && m_data.intensity_percent == '0))
        else $error("nonzero statistics before calibration");

    a_pct_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pct_reg <= PCT_MAX)
        else $error("held percentage above full scale");

endmodule
